[hdl/mva_pkg.sv]
`timescale 1ns / 1ps

package mva_pkg;

   // default sizes of the filter
   localparam int MVA_MAX_WINDOW  = 16;
   localparam int MVA_SAMPLE_BITS = 32;

   // window_size register
   localparam int                  MVA_WS_W     = 5;
   localparam logic [MVA_WS_W-1:0] MVA_WS_RESET = 5'd1;

   // x, y and z lanes
   localparam int MVA_AXES = 3;

   // status of the shared divider
   typedef struct packed {
      logic busy;
      logic done;
   } mva_div_status_type;

endpackage

[hdl/vector_moving_average.sv]
`timescale 1ns / 1ps

// Three-axis boxcar moving average. Each req transfer carries one x/y/z rate
// sample; each rsp transfer returns the mean of the last window_size samples
// per axis, truncated toward zero. With window_size 0 or 1 the sample passes
// straight through the result and rsp registers. Otherwise the block keeps a ring of
// samples in a small RAM and a running sum per axis, and divides each sum by
// the window length in one shared restoring divider, one quotient bit per
// cycle, taking the axes in turn. Once a result is in the rsp register the
// block is idle again and can take the next sample; the first averaged item
// after reset or after a write of window_size first fills the window, one
// RAM entry per cycle. req_ready is high only while the block is idle, and a
// finished result waits in the rsp register while the next sample is taken.
// window_size above MAX_WINDOW counts as MAX_WINDOW; write it only while no
// sample is in flight.
module vector_moving_average
   import mva_pkg::*;
#(
   parameter int MAX_WINDOW  = MVA_MAX_WINDOW,
   parameter int SAMPLE_BITS = MVA_SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   // sample channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_rate_x,
   input  logic signed [SAMPLE_BITS-1:0] req_rate_y,
   input  logic signed [SAMPLE_BITS-1:0] req_rate_z,
   // average channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_avg_x,
   output logic signed [SAMPLE_BITS-1:0] rsp_avg_y,
   output logic signed [SAMPLE_BITS-1:0] rsp_avg_z,
   // window_size register
   input  logic                          csr_wr_en,
   input  logic [MVA_WS_W-1:0]           csr_wr_data
);

   // ring index width and running sum width
   localparam int POS_W   = $clog2(MAX_WINDOW);
   localparam int SUM_W   = SAMPLE_BITS + POS_W;
   // largest window the 5-bit register can actually select
   localparam int N_LIMIT = (MAX_WINDOW < 31) ? MAX_WINDOW : 31;
   localparam int MEM_W   = MVA_AXES * SAMPLE_BITS;

   localparam logic [1:0] AXIS_FIRST = 2'd0;
   localparam logic [1:0] AXIS_LAST  = 2'(MVA_AXES - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_FILL,
      S_ADV,
      S_READ,
      S_UPD,
      S_DIV,
      S_OUT
   } state_type;

   state_type state_ff, state_in;

   logic [MVA_WS_W-1:0] window_size_ff, window_size_in;
   logic                primed_ff, primed_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [POS_W-1:0]    fill_cnt_ff, fill_cnt_in;
   logic [1:0]          axis_ff, axis_in;
   logic                div_start_ff, div_start_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic signed [SAMPLE_BITS-1:0] samp_ff [MVA_AXES];
   logic signed [SAMPLE_BITS-1:0] samp_in [MVA_AXES];
   logic signed [SUM_W-1:0]       sum_ff  [MVA_AXES];
   logic signed [SUM_W-1:0]       sum_in  [MVA_AXES];
   logic signed [SAMPLE_BITS-1:0] res_ff  [MVA_AXES];
   logic signed [SAMPLE_BITS-1:0] res_in  [MVA_AXES];
   logic signed [SAMPLE_BITS-1:0] rsp_ff  [MVA_AXES];
   logic signed [SAMPLE_BITS-1:0] rsp_in  [MVA_AXES];

   // effective window length and ring stepping
   logic [MVA_WS_W-1:0] win_n;
   logic                averaging;
   logic [POS_W:0]      pos_inc;
   logic [POS_W-1:0]    pos_next;
   logic                fill_last;

   // window RAM, lanes packed x in the low bits
   logic                          mem_wr_en;
   logic [POS_W-1:0]              mem_wr_addr;
   logic [MEM_W-1:0]              mem_wr_data;
   logic [MEM_W-1:0]              mem_rd_data;
   logic signed [SAMPLE_BITS-1:0] rd_old [MVA_AXES];

   // shared divider
   mva_div_status_type      div_status;
   logic signed [SUM_W-1:0] sel_sum;
   logic                    sel_neg;
   logic [SUM_W-1:0]        div_dividend;
   logic [SUM_W-1:0]        div_quotient;
   logic [SUM_W-1:0]        q_fixed;

   assign win_n = (32'(window_size_ff) > 32'(N_LIMIT)) ? MVA_WS_W'(N_LIMIT)
                                                        : window_size_ff;
   assign averaging = (win_n >= MVA_WS_W'(2));

   // increment wraps when it reaches the window, also after a shrink
   assign pos_inc   = {1'b0, pos_ff} + (POS_W + 1)'(1);
   assign pos_next  = (32'(pos_inc) >= 32'(win_n)) ? '0 : pos_inc[POS_W-1:0];
   assign fill_last = ((32'(fill_cnt_ff) + 32'd1) == 32'(win_n));

   assign mem_wr_en   = (state_ff == S_FILL) || (state_ff == S_UPD);
   assign mem_wr_addr = (state_ff == S_FILL) ? fill_cnt_ff : pos_ff;
   assign mem_wr_data = {samp_ff[2], samp_ff[1], samp_ff[0]};

   mva_window_ram #(
      .DEPTH (MAX_WINDOW),
      .WIDTH (MEM_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (pos_ff),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      for (int a = 0; a < MVA_AXES; a++) begin
         rd_old[a] = mem_rd_data[a*SAMPLE_BITS +: SAMPLE_BITS];
      end
   end

   // divide the magnitude, put the sign back afterwards (truncation toward zero)
   assign sel_sum      = sum_ff[axis_ff];
   assign sel_neg      = sel_sum[SUM_W-1];
   assign div_dividend = sel_neg ? SUM_W'(-sel_sum) : SUM_W'(sel_sum);
   assign q_fixed      = sel_neg ? (-div_quotient) : div_quotient;

   mva_divider #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (MVA_WS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_dividend),
      .divisor  (win_n),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // sequencer
   always_comb begin
      state_in       = state_ff;
      window_size_in = window_size_ff;
      primed_in      = primed_ff;
      pos_in         = pos_ff;
      fill_cnt_in    = fill_cnt_ff;
      axis_in        = axis_ff;
      div_start_in   = 1'b0;
      rsp_valid_in   = rsp_valid_ff;
      samp_in        = samp_ff;
      sum_in         = sum_ff;
      res_in         = res_ff;
      rsp_in         = rsp_ff;

      // downstream took the held result
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               samp_in[0] = req_rate_x;
               samp_in[1] = req_rate_y;
               samp_in[2] = req_rate_z;
               if (!averaging) begin
                  // pass through, filter state untouched
                  res_in[0] = req_rate_x;
                  res_in[1] = req_rate_y;
                  res_in[2] = req_rate_z;
                  state_in  = S_OUT;
               end else if (!primed_ff) begin
                  fill_cnt_in = '0;
                  for (int a = 0; a < MVA_AXES; a++) begin
                     sum_in[a] = '0;
                  end
                  state_in = S_FILL;
               end else begin
                  state_in = S_ADV;
               end
            end
         end
         S_FILL: begin
            // one entry per cycle, sum builds up to sample * window
            for (int a = 0; a < MVA_AXES; a++) begin
               sum_in[a] = sum_ff[a] + SUM_W'(samp_ff[a]);
            end
            fill_cnt_in = fill_cnt_ff + POS_W'(1);
            if (fill_last) begin
               primed_in = 1'b1;
               state_in  = S_ADV;
            end
         end
         S_ADV: begin
            pos_in   = pos_next;
            state_in = S_READ;
         end
         S_READ: begin
            // oldest entry lands in the RAM output register
            state_in = S_UPD;
         end
         S_UPD: begin
            for (int a = 0; a < MVA_AXES; a++) begin
               sum_in[a] = sum_ff[a] - SUM_W'(rd_old[a]) + SUM_W'(samp_ff[a]);
            end
            axis_in      = AXIS_FIRST;
            div_start_in = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            if (div_status.done) begin
               res_in[axis_ff] = q_fixed[SAMPLE_BITS-1:0];
               if (axis_ff == AXIS_LAST) begin
                  state_in = S_OUT;
               end else begin
                  axis_in      = axis_ff + 2'd1;
                  div_start_in = 1'b1;
               end
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // register write re-arms the window fill
      if (csr_wr_en) begin
         window_size_in = csr_wr_data;
         primed_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         window_size_ff <= MVA_WS_RESET;
         primed_ff      <= 1'b0;
         pos_ff         <= '0;
         fill_cnt_ff    <= '0;
         axis_ff        <= AXIS_FIRST;
         div_start_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         for (int a = 0; a < MVA_AXES; a++) begin
            sum_ff[a] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         window_size_ff <= window_size_in;
         primed_ff      <= primed_in;
         pos_ff         <= pos_in;
         fill_cnt_ff    <= fill_cnt_in;
         axis_ff        <= axis_in;
         div_start_ff   <= div_start_in;
         rsp_valid_ff   <= rsp_valid_in;
         sum_ff         <= sum_in;
      end
      samp_ff <= samp_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_avg_x = rsp_ff[0];
   assign rsp_avg_y = rsp_ff[1];
   assign rsp_avg_z = rsp_ff[2];

   // divider only runs while an average is being formed
   a_div_in_seq: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> (state_ff == S_DIV))
      else $error("divider busy outside the divide phase");

   // a register write always forces a refill
   a_csr_rearm: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> !primed_ff)
      else $error("window not re-armed after window_size write");

   // ring index stays inside the active window when an entry is replaced
   a_pos_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD) |-> (32'(pos_ff) < 32'(win_n)))
      else $error("ring position outside the window");

   // pass-through samples skip straight to the result register
   a_pass_through: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !averaging && !csr_wr_en) |=> (state_ff == S_OUT))
      else $error("pass-through sample did not go to output");

endmodule

[hdl/mva_window_ram.sv]
`timescale 1ns / 1ps

module mva_window_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 96
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] window_mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         window_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= window_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/mva_divider.sv]
`timescale 1ns / 1ps

module mva_divider
   import mva_pkg::*;
#(
   parameter int DIVIDEND_W = 36,
   parameter int DIVISOR_W  = MVA_WS_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output mva_div_status_type    status,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  div_ff, div_in;

   logic [DIVISOR_W:0] trial;
   logic [DIVISOR_W:0] diff;
   logic               fits;

   // restoring division, one quotient bit per cycle, msb first
   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = (trial >= {1'b0, div_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule
